FILE: rtl/core/vector_distance_isqrt_unit_assert.svh
// Assertion macros for the vector distance unit checker.
// Depends on nothing; included by the checker file.
`ifndef VECTOR_DISTANCE_ISQRT_UNIT_ASSERT_SVH
`define VECTOR_DISTANCE_ISQRT_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define VDI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vdi assertion failed");

// next-cycle implication, off during reset
`define VDI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vdi assertion failed");

// next-cycle implication, always on
`define VDI_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("vdi assertion failed");

`endif

FILE: rtl/core/vdi_pkg.sv
// Shared widths, root stage state type and the root step function.
// No dependencies; used by the interfaces, the pipeline modules and the checker.
package vdi_pkg;

   localparam int COORD_BITS      = 16;
   localparam int DIST_BITS       = COORD_BITS + 1;
   localparam int ABS_BITS        = COORD_BITS;
   localparam int SQ_BITS         = 2 * COORD_BITS;
   localparam int SUM_BITS        = SQ_BITS + 1;
   localparam int RAD_BITS        = 2 * DIST_BITS;
   localparam int REM_BITS        = DIST_BITS + 3;
   localparam int ROOT_STEPS      = DIST_BITS;
   localparam int STEPS_PER_STAGE = 2;
   localparam int ROOT_STAGES     = (ROOT_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   typedef struct packed {
      logic [RAD_BITS-1:0]  rad;
      logic [REM_BITS-1:0]  rem;
      logic [DIST_BITS-1:0] root;
   } root_state_type;

   // one bit-pair restoring step: bring down the next pair, try 4*root+1
   function automatic root_state_type root_step(input root_state_type cur);
      root_state_type       nxt;
      logic [REM_BITS-1:0]  rem_sh;
      logic [REM_BITS-1:0]  trial;
      rem_sh  = {cur.rem[REM_BITS-3:0], cur.rad[RAD_BITS-1 -: 2]};
      trial   = {1'b0, cur.root, 2'b01};
      nxt.rad = {cur.rad[RAD_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
         nxt.rem  = rem_sh - trial;
         nxt.root = {cur.root[DIST_BITS-2:0], 1'b1};
      end else begin
         nxt.rem  = rem_sh;
         nxt.root = {cur.root[DIST_BITS-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

FILE: rtl/core/vdi_if.sv
// Valid/ready channel interfaces for point pairs and distances.
// Depends on vdi_pkg.
interface vdi_req_if import vdi_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] src_x;
   logic signed [COORD_BITS-1:0] src_y;
   logic signed [COORD_BITS-1:0] dst_x;
   logic signed [COORD_BITS-1:0] dst_y;

   modport source (output valid, src_x, src_y, dst_x, dst_y, input ready);
   modport sink   (input valid, src_x, src_y, dst_x, dst_y, output ready);
endinterface

interface vdi_rsp_if import vdi_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DIST_BITS-1:0] distance;

   modport source (output valid, distance, input ready);
   modport sink   (input valid, distance, output ready);
endinterface

FILE: rtl/core/vdi_root_pipe.sv
// Pipelined bit-pair restoring square root, two steps per register stage (one in the last).
// Depends on vdi_pkg and vdi_rsp_if; drives the result channel.
module vdi_root_pipe import vdi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SUM_BITS-1:0] in_sum,
   vdi_rsp_if.source           rsp_chan
);

   logic [ROOT_STAGES-1:0] valid_ff;
   logic [ROOT_STAGES:0]   stage_ready;
   root_state_type         state_ff [ROOT_STAGES];
   root_state_type         state_in [ROOT_STAGES];
   root_state_type         init_state;

   assign init_state.rad  = RAD_BITS'(in_sum);
   assign init_state.rem  = '0;
   assign init_state.root = '0;

   assign stage_ready[ROOT_STAGES] = rsp_chan.ready;
   assign in_ready                 = stage_ready[0];

   for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
      root_state_type step_val [STEPS_PER_STAGE+1];
      logic           up_valid;

      if (s == 0) begin : g_first
         assign step_val[0] = init_state;
         assign up_valid    = in_valid;
      end else begin : g_rest
         assign step_val[0] = state_ff[s-1];
         assign up_valid    = valid_ff[s-1];
      end

      for (genvar k = 0; k < STEPS_PER_STAGE; k++) begin : g_step
         if (s * STEPS_PER_STAGE + k < ROOT_STEPS) begin : g_do
            assign step_val[k+1] = root_step(step_val[k]);
         end else begin : g_pass
            assign step_val[k+1] = step_val[k];
         end
      end

      assign state_in[s]    = step_val[STEPS_PER_STAGE];
      assign stage_ready[s] = !valid_ff[s] || stage_ready[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (stage_ready[s]) begin
            valid_ff[s] <= up_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[s]) begin
            state_ff[s] <= state_in[s];
         end
      end
   end

   assign rsp_chan.valid    = valid_ff[ROOT_STAGES-1];
   assign rsp_chan.distance = state_ff[ROOT_STAGES-1].root;

endmodule

FILE: rtl/core/vector_distance_isqrt_unit.sv
// Top level of the vector distance unit: differences, squares, sum, root pipeline.
// Depends on vdi_pkg, vdi_req_if, vdi_rsp_if and vdi_root_pipe.
//
// Returns floor(sqrt(dx*dx + dy*dy)) for each pair of signed points, one result per
// pair, in order. A new pair is taken every cycle while the output is not stalled; the
// pipeline has one stage each for the absolute differences, the two 16x16 squares
// and their sum, then nine stages of square root, each resolving two result bits but
// the last, which resolves one.
// A low rsp ready stalls the pipeline in place; bubbles are squeezed out first.
module vector_distance_isqrt_unit import vdi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   vdi_req_if.sink   req_chan,
   vdi_rsp_if.source rsp_chan
);

   logic                abs_valid_ff;
   logic [ABS_BITS-1:0] abs_x_ff, abs_x_in;
   logic [ABS_BITS-1:0] abs_y_ff, abs_y_in;
   logic                sq_valid_ff;
   logic [SQ_BITS-1:0]  sq_x_ff, sq_x_in;
   logic [SQ_BITS-1:0]  sq_y_ff, sq_y_in;
   logic                sum_valid_ff;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic                abs_ready, sq_ready, sum_ready, root_ready;
   logic [COORD_BITS:0] diff_x, diff_y;
   logic [COORD_BITS:0] mag_x, mag_y;

   // stage ready: take a transfer when empty or when the stage ahead moves
   assign sum_ready      = !sum_valid_ff || root_ready;
   assign sq_ready       = !sq_valid_ff || sum_ready;
   assign abs_ready      = !abs_valid_ff || sq_ready;
   assign req_chan.ready = abs_ready;

   always_comb begin
      diff_x   = {req_chan.dst_x[COORD_BITS-1], req_chan.dst_x}
               - {req_chan.src_x[COORD_BITS-1], req_chan.src_x};
      diff_y   = {req_chan.dst_y[COORD_BITS-1], req_chan.dst_y}
               - {req_chan.src_y[COORD_BITS-1], req_chan.src_y};
      mag_x    = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
      mag_y    = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;
      abs_x_in = mag_x[ABS_BITS-1:0];
      abs_y_in = mag_y[ABS_BITS-1:0];
      sq_x_in  = SQ_BITS'(abs_x_ff) * SQ_BITS'(abs_x_ff);
      sq_y_in  = SQ_BITS'(abs_y_ff) * SQ_BITS'(abs_y_ff);
      sum_in   = SUM_BITS'(sq_x_ff) + SUM_BITS'(sq_y_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_valid_ff <= 1'b0;
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (abs_ready) begin
            abs_valid_ff <= req_chan.valid;
         end
         if (sq_ready) begin
            sq_valid_ff <= abs_valid_ff;
         end
         if (sum_ready) begin
            sum_valid_ff <= sq_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (abs_ready) begin
         abs_x_ff <= abs_x_in;
         abs_y_ff <= abs_y_in;
      end
      if (sq_ready) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
      end
      if (sum_ready) begin
         sum_ff <= sum_in;
      end
   end

   vdi_root_pipe u_root (
      .clock    (clock),
      .reset    (reset),
      .in_valid (sum_valid_ff),
      .in_ready (root_ready),
      .in_sum   (sum_ff),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: rtl/core/vdi_checker.sv
// Port-level checker for the vector distance unit, with its bind statement.
// Depends on vdi_pkg and vector_distance_isqrt_unit_assert.svh.
`include "vector_distance_isqrt_unit_assert.svh"

module vdi_checker import vdi_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [DIST_BITS-1:0] rsp_distance
);

   `VDI_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `VDI_ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_distance))
   `VDI_ASSERT_NOW(a_stall_only_full, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `VDI_ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_valid)

endmodule

bind vector_distance_isqrt_unit vdi_checker u_vdi_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_distance (rsp_chan.distance)
);
